// ----- rtl/bvs_pkg.sv -----
// bvs_pkg: shared constants for the branching variable selector
// selection rule codes, register map and fixed field widths
// no dependencies
package bvs_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned RULE_W = 3;
	localparam int unsigned PADDR_W = 2;
	localparam int unsigned PDATA_W = 32;

	localparam int unsigned MAX_VARS_DEF = 1024;
	localparam int unsigned FRAC_BITS_DEF = 16;

	// register map
	localparam logic [PADDR_W-1:0] RULE_ADDR = 2'd0;

	typedef enum logic [RULE_W-1:0] {
		RULE_MOST_FRAC = 3'd0,
		RULE_SMALL_MAG = 3'd1,
		RULE_LAST_SMALL = 3'd2,
		RULE_LAST_NONINT = 3'd3,
		RULE_FIRST_PRIO = 3'd4,
		RULE_LAST_PRIO = 3'd5
	} rule_t;

endpackage

// ----- rtl/branching_variable_selector_unit.sv -----
// Scans a relaxation solution one variable per transfer and selects a branching variable.
// A result (chosen, found) is produced for each vector, on the transfer that carries last = 1.
// Uses bvs_pkg for the rule codes and the register map.
//
// One variable is taken per clock cycle, unless in_stall is high, with no gaps between
// vectors. The input register feeds a single compare-and-update stage for all rule
// trackers, so a result is registered in the output register when the last transfer of
// its vector advances out of the input register. Input stall rises only while a last item
// waits in the input register and the previous result is still held, unaccepted, in the
// output register. Each vector's trackers restart as its last item leaves the input
// register. The rule register (address 0) is sampled when the last item is processed;
// codes 6 and 7 give found = 0.
module branching_variable_selector_unit import bvs_pkg::*; #(
	parameter int unsigned MAX_VARS = MAX_VARS_DEF,
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready,
	// solution stream
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [$clog2(MAX_VARS)-1:0] var_number,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic                       bounds_equal,
	input  logic                       last,
	// selection result
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [$clog2(MAX_VARS)-1:0] chosen,
	output logic                       found
);

	localparam int unsigned NUM_W = $clog2(MAX_VARS);
	localparam int unsigned MAG_W = FRAC_BITS + 1;
	localparam logic [MAG_W-1:0] ONE_FX = MAG_W'(1) << FRAC_BITS;

	// configuration register
	logic [RULE_W-1:0] rule_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == RULE_ADDR);
	assign prdata = (paddr == RULE_ADDR) ? PDATA_W'(rule_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= RULE_MOST_FRAC;
		end else if (cfg_wr) begin
			rule_q <= pwdata[RULE_W-1:0];
		end
	end

	// input register
	logic                      valid_s1;
	logic [NUM_W-1:0]          num_s1;
	logic [VALUE_W-1:0]        raw_s1;
	logic                      fixed_s1;
	logic                      last_s1;
	logic                      adv_s1;
	logic                      take_in;
	logic                      out_valid_q;

	assign adv_s1 = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in || in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			num_s1 <= var_number;
			raw_s1 <= value;
			fixed_s1 <= bounds_equal;
			last_s1 <= last;
		end
	end

	// value classification
	logic                 neg;
	logic [VALUE_W-1:0]   mag;
	logic [FRAC_BITS-1:0] frac;
	logic [MAG_W-1:0]     one_minus_f;
	logic [FRAC_BITS-1:0] round_dist;
	logic                 nonint;
	logic                 below_one;

	always_comb begin
		neg = raw_s1[VALUE_W-1];
		mag = neg ? (~raw_s1 + VALUE_W'(1)) : raw_s1;
		frac = raw_s1[FRAC_BITS-1:0];
		one_minus_f = ONE_FX - MAG_W'(frac);
		round_dist = (MAG_W'(frac) < one_minus_f) ? frac : one_minus_f[FRAC_BITS-1:0];
		nonint = (frac != '0);
		below_one = (raw_s1 != '0) && (mag < VALUE_W'(ONE_FX));
	end

	// trackers
	logic [FRAC_BITS-1:0] frac_dist_q;
	logic [NUM_W-1:0]     frac_num_q;
	logic                 frac_valid_q;
	logic [MAG_W-1:0]     small_mag_q;
	logic [NUM_W-1:0]     small_num_q;
	logic                 small_valid_q;
	logic [NUM_W-1:0]     last_small_num_q;
	logic                 last_small_valid_q;
	logic [NUM_W-1:0]     first_nonint_num_q;
	logic                 first_nonint_valid_q;
	logic [NUM_W-1:0]     last_nonint_num_q;
	logic                 last_nonint_valid_q;

	logic [FRAC_BITS-1:0] frac_dist_d;
	logic [NUM_W-1:0]     frac_num_d;
	logic                 frac_valid_d;
	logic [MAG_W-1:0]     small_mag_d;
	logic [NUM_W-1:0]     small_num_d;
	logic                 small_valid_d;
	logic [NUM_W-1:0]     last_small_num_d;
	logic                 last_small_valid_d;
	logic [NUM_W-1:0]     first_nonint_num_d;
	logic                 first_nonint_valid_d;
	logic [NUM_W-1:0]     last_nonint_num_d;
	logic                 last_nonint_valid_d;

	always_comb begin
		frac_dist_d = frac_dist_q;
		frac_num_d = frac_num_q;
		frac_valid_d = frac_valid_q;
		small_mag_d = small_mag_q;
		small_num_d = small_num_q;
		small_valid_d = small_valid_q;
		last_small_num_d = last_small_num_q;
		last_small_valid_d = last_small_valid_q;
		first_nonint_num_d = first_nonint_num_q;
		first_nonint_valid_d = first_nonint_valid_q;
		last_nonint_num_d = last_nonint_num_q;
		last_nonint_valid_d = last_nonint_valid_q;

		// later item wins ties
		if (frac_dist_q <= round_dist) begin
			frac_dist_d = round_dist;
			frac_num_d = num_s1;
			frac_valid_d = 1'b1;
		end
		// earlier item wins ties; below_one keeps mag under one so the low bits suffice
		if (!fixed_s1 && below_one && (mag[MAG_W-1:0] < small_mag_q)) begin
			small_mag_d = mag[MAG_W-1:0];
			small_num_d = num_s1;
			small_valid_d = 1'b1;
		end
		if (below_one) begin
			last_small_num_d = num_s1;
			last_small_valid_d = 1'b1;
		end
		if (nonint) begin
			if (!first_nonint_valid_q) begin
				first_nonint_num_d = num_s1;
				first_nonint_valid_d = 1'b1;
			end
			last_nonint_num_d = num_s1;
			last_nonint_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_dist_q <= '0;
			frac_num_q <= '0;
			frac_valid_q <= 1'b0;
			small_mag_q <= ONE_FX;
			small_num_q <= '0;
			small_valid_q <= 1'b0;
			last_small_num_q <= '0;
			last_small_valid_q <= 1'b0;
			first_nonint_num_q <= '0;
			first_nonint_valid_q <= 1'b0;
			last_nonint_num_q <= '0;
			last_nonint_valid_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				// vector closed: restart all trackers
				frac_dist_q <= '0;
				frac_num_q <= '0;
				frac_valid_q <= 1'b0;
				small_mag_q <= ONE_FX;
				small_num_q <= '0;
				small_valid_q <= 1'b0;
				last_small_num_q <= '0;
				last_small_valid_q <= 1'b0;
				first_nonint_num_q <= '0;
				first_nonint_valid_q <= 1'b0;
				last_nonint_num_q <= '0;
				last_nonint_valid_q <= 1'b0;
			end else begin
				frac_dist_q <= frac_dist_d;
				frac_num_q <= frac_num_d;
				frac_valid_q <= frac_valid_d;
				small_mag_q <= small_mag_d;
				small_num_q <= small_num_d;
				small_valid_q <= small_valid_d;
				last_small_num_q <= last_small_num_d;
				last_small_valid_q <= last_small_valid_d;
				first_nonint_num_q <= first_nonint_num_d;
				first_nonint_valid_q <= first_nonint_valid_d;
				last_nonint_num_q <= last_nonint_num_d;
				last_nonint_valid_q <= last_nonint_valid_d;
			end
		end
	end

	// rule selection from the updated trackers
	logic [NUM_W-1:0] sel_num;
	logic             sel_found;

	always_comb begin
		sel_num = '0;
		sel_found = 1'b0;
		case (rule_q)
			RULE_MOST_FRAC: begin
				sel_found = frac_valid_d;
				sel_num = frac_num_d;
			end
			RULE_SMALL_MAG: begin
				if (small_valid_d) begin
					sel_found = 1'b1;
					sel_num = small_num_d;
				end else begin
					sel_found = frac_valid_d;
					sel_num = frac_num_d;
				end
			end
			RULE_LAST_SMALL: begin
				if (last_small_valid_d) begin
					sel_found = 1'b1;
					sel_num = last_small_num_d;
				end else begin
					sel_found = frac_valid_d;
					sel_num = frac_num_d;
				end
			end
			RULE_LAST_NONINT, RULE_LAST_PRIO: begin
				sel_found = last_nonint_valid_d;
				sel_num = last_nonint_num_d;
			end
			RULE_FIRST_PRIO: begin
				sel_found = first_nonint_valid_d;
				sel_num = first_nonint_num_d;
			end
			default: begin
				sel_found = 1'b0;
				sel_num = '0;
			end
		endcase
		if (!sel_found) begin
			sel_num = '0;
		end
	end

	// output register
	logic             out_load;
	logic [NUM_W-1:0] chosen_q;
	logic             found_q;

	assign out_load = adv_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			chosen_q <= sel_num;
			found_q <= sel_found;
		end
	end

	assign out_valid = out_valid_q;
	assign chosen = chosen_q;
	assign found = found_q;

endmodule

// ----- tb/sv/bvs_selection_checker.sv -----
// bvs_selection_checker: watches the register port and both streams of the selector,
// predicts each selection and compares it with the result transfer
// depends on bvs_pkg for widths, rule codes and the register map
module bvs_selection_checker import bvs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [PADDR_W-1:0]           paddr,
	input  logic [PDATA_W-1:0]           pwdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [$clog2(MAX_VARS_DEF)-1:0] var_number,
	input  logic signed [VALUE_W-1:0]    value,
	input  logic                         bounds_equal,
	input  logic                         last,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [$clog2(MAX_VARS_DEF)-1:0] chosen,
	input  logic                         found,
	output int unsigned                  failures,
	output int unsigned                  pending
);

	localparam int unsigned NUM_W = $clog2(MAX_VARS_DEF);
	localparam logic [VALUE_W:0] ONE_FX = 33'd1 << FRAC_BITS_DEF;

	typedef struct packed {
		logic [NUM_W-1:0] chosen;
		logic             found;
	} selection_t;

	selection_t selections_due[$];
	logic [RULE_W-1:0] rule_reg;

	// running candidates for the selection rules; last-nonint and last-prio share one set
	logic [FRAC_BITS_DEF-1:0] best_dist;
	logic [NUM_W-1:0]         most_frac_num;
	logic                     have_frac;
	logic [VALUE_W:0]         least_mag;
	logic [NUM_W-1:0]         least_mag_num;
	logic                     have_least;
	logic [NUM_W-1:0]         last_small_num;
	logic                     have_last_small;
	logic [NUM_W-1:0]         first_nonint_num;
	logic                     have_first_nonint;
	logic [NUM_W-1:0]         last_nonint_num;
	logic                     have_last_nonint;

	task clear_trackers;
		best_dist = '0;
		most_frac_num = '0;
		have_frac = 1'b0;
		least_mag = ONE_FX;
		least_mag_num = '0;
		have_least = 1'b0;
		last_small_num = '0;
		have_last_small = 1'b0;
		first_nonint_num = '0;
		have_first_nonint = 1'b0;
		last_nonint_num = '0;
		have_last_nonint = 1'b0;
	endtask

	task scan_variable(input logic [NUM_W-1:0] num, input logic [VALUE_W-1:0] raw,
			input logic fixed, input logic closes);
		logic [VALUE_W:0] mag;
		logic [VALUE_W:0] frac;
		logic [VALUE_W:0] round_dist;
		logic nonint;
		logic small_mag;
		selection_t sel;
		mag = raw[VALUE_W-1] ? ((33'd1 << VALUE_W) - {1'b0, raw}) : {1'b0, raw};
		frac = 33'(raw[FRAC_BITS_DEF-1:0]);
		round_dist = (frac < ONE_FX - frac) ? frac : ONE_FX - frac;
		nonint = frac != 0;
		small_mag = raw != 0 && mag < ONE_FX;

		// later variable wins ties on fraction distance
		if (round_dist >= 33'(best_dist)) begin
			best_dist = round_dist[FRAC_BITS_DEF-1:0];
			most_frac_num = num;
			have_frac = 1'b1;
		end
		// earlier variable wins ties on magnitude
		if (!fixed && small_mag && mag < least_mag) begin
			least_mag = mag;
			least_mag_num = num;
			have_least = 1'b1;
		end
		if (small_mag) begin
			last_small_num = num;
			have_last_small = 1'b1;
		end
		if (nonint) begin
			if (!have_first_nonint) begin
				first_nonint_num = num;
				have_first_nonint = 1'b1;
			end
			last_nonint_num = num;
			have_last_nonint = 1'b1;
		end

		if (closes) begin
			sel = '0;
			case (rule_reg)
				RULE_MOST_FRAC: begin
					sel.found = have_frac;
					sel.chosen = most_frac_num;
				end
				RULE_SMALL_MAG: begin
					sel.found = have_least | have_frac;
					sel.chosen = have_least ? least_mag_num : most_frac_num;
				end
				RULE_LAST_SMALL: begin
					sel.found = have_last_small | have_frac;
					sel.chosen = have_last_small ? last_small_num : most_frac_num;
				end
				RULE_LAST_NONINT, RULE_LAST_PRIO: begin
					sel.found = have_last_nonint;
					sel.chosen = last_nonint_num;
				end
				RULE_FIRST_PRIO: begin
					sel.found = have_first_nonint;
					sel.chosen = first_nonint_num;
				end
				default: sel = '0;
			endcase
			if (!sel.found)
				sel.chosen = '0;
			selections_due = {selections_due, sel};
			clear_trackers();
		end
	endtask

	task compare_selection;
		selection_t want;
		if (selections_due.size() == 0) begin
			if (failures < 10)
				$display("%0t: selection chosen=%0d found=%0b with none outstanding",
					$time, chosen, found);
			failures++;
		end else begin
			want = selections_due.pop_front();
			if (want.chosen !== chosen || want.found !== found) begin
				if (failures < 10)
					$display("%0t: mismatch: expected chosen=%0d found=%0b, got %0d %0b",
						$time, want.chosen, want.found, chosen, found);
				failures++;
			end
		end
	endtask

	initial failures = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_reg = RULE_MOST_FRAC;
			clear_trackers();
			selections_due.delete();
		end else begin
			if (out_valid && !out_stall)
				compare_selection();
			if (psel && penable && pwrite && pready && paddr == RULE_ADDR)
				rule_reg = pwdata[RULE_W-1:0];
			if (in_valid && !in_stall)
				scan_variable(var_number, value, bounds_equal, last);
		end
		pending = selections_due.size();
	end

endmodule

// ----- tb/sv/branching_variable_selector_unit_test.sv -----
// branching_variable_selector_unit_test: drives solution vectors and rule writes into the
// selector, with random gaps on both streams and one long output hold-off
// depends on bvs_pkg, branching_variable_selector_unit and bvs_selection_checker
module branching_variable_selector_unit_test;
	import bvs_pkg::*;

	localparam int unsigned NUM_W = $clog2(MAX_VARS_DEF);
	// codes with no rule behind them
	localparam logic [RULE_W-1:0] RULE_UNUSED_6 = 3'd6;
	localparam logic [RULE_W-1:0] RULE_UNUSED_7 = 3'd7;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic in_valid, in_stall;
	logic [NUM_W-1:0] var_number;
	logic signed [VALUE_W-1:0] value;
	logic bounds_equal, last;
	logic out_valid, out_stall;
	logic [NUM_W-1:0] chosen;
	logic found;
	int unsigned failures, pending;

	int unsigned idle_pct;
	logic hold_req;
	int unsigned quiet_cycles;

	branching_variable_selector_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .var_number(var_number),
		.value(value), .bounds_equal(bounds_equal), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .chosen(chosen), .found(found)
	);

	bvs_selection_checker selection_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .var_number(var_number),
		.value(value), .bounds_equal(bounds_equal), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .chosen(chosen), .found(found),
		.failures(failures), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic send_item(input logic [NUM_W-1:0] num, input logic [VALUE_W-1:0] val,
			input logic fixed, input logic closes);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		var_number <= num;
		value <= val;
		bounds_equal <= fixed;
		last <= closes;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// waits until no selection is outstanding, then writes the rule register
	task automatic write_rule(input logic [RULE_W-1:0] code);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RULE_ADDR;
		pwdata <= PDATA_W'(code);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin
		bit hold_used;
		hold_used = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles <= 0;
			else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("branching_variable_selector_unit_test: done, errors");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int sent, len;
		logic [NUM_W-1:0] num;
		logic [VALUE_W-1:0] v;
		bit in_order;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		var_number = '0;
		value = '0;
		bounds_equal = 1'b0;
		last = 1'b0;
		idle_pct = 16;
		hold_req = 1'b0;
		quiet_cycles = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed vectors
		write_rule(RULE_MOST_FRAC);
		send_item(10'd0, 32'h8000_0000, 1'b0, 1'b0);
		send_item(10'd1023, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_item(10'd5, 32'h0000_8000, 1'b0, 1'b0);
		send_item(10'd6, 32'hFFFF_8000, 1'b0, 1'b0);
		send_item(10'd7, 32'h0000_0000, 1'b1, 1'b1);
		write_rule(RULE_SMALL_MAG);
		send_item(10'd10, 32'h0000_0001, 1'b1, 1'b0);
		send_item(10'd11, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_item(10'd12, 32'h0000_0001, 1'b0, 1'b0);
		send_item(10'd13, 32'h0001_0000, 1'b0, 1'b1);
		// all integer, falls back to most fractional
		send_item(10'd20, 32'h0001_0000, 1'b0, 1'b0);
		send_item(10'd21, 32'hFFFF_0000, 1'b0, 1'b1);
		write_rule(RULE_LAST_SMALL);
		send_item(10'd30, 32'h0000_4000, 1'b1, 1'b0);
		send_item(10'd31, 32'h0003_0000, 1'b0, 1'b1);
		write_rule(RULE_LAST_NONINT);
		send_item(10'd40, 32'h0000_0000, 1'b0, 1'b1);
		write_rule(RULE_FIRST_PRIO);
		send_item(10'd50, 32'h0001_8000, 1'b0, 1'b0);
		send_item(10'd51, 32'h0001_4000, 1'b0, 1'b0);
		send_item(10'd52, 32'h0000_0005, 1'b0, 1'b1);
		write_rule(RULE_LAST_PRIO);
		send_item(10'd50, 32'h0001_8000, 1'b0, 1'b0);
		send_item(10'd51, 32'h0001_4000, 1'b0, 1'b0);
		send_item(10'd52, 32'h0000_0005, 1'b0, 1'b1);
		write_rule(RULE_UNUSED_6);
		send_item(10'd60, 32'h0000_8000, 1'b0, 1'b1);
		write_rule(RULE_UNUSED_7);
		send_item(10'd61, 32'h0000_8000, 1'b0, 1'b0);
		// rule changes while a vector is half done
		write_rule(RULE_FIRST_PRIO);
		send_item(10'd70, 32'h0001_2345, 1'b0, 1'b1);

		for (int phase = 0; phase < 20; phase++) begin
			write_rule(phase < 8 ? RULE_W'(phase) : RULE_W'($urandom_range(7)));
			idle_pct <= (phase >= 6 && phase <= 8) ? 0 : 16;
			hold_req <= (phase == 14);
			sent = 0;
			while (sent < 34) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				in_order = $urandom_range(4) != 0;
				num = NUM_W'($urandom_range(1023));
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(7))
						0: v = {16'($urandom), 16'h0000};
						1: v = 32'($urandom_range(16'hFFFF, 1));
						2: v = -32'($urandom_range(16'hFFFF, 1));
						3: v = {16'($urandom), 16'h8000};
						4: begin
							case ($urandom_range(5))
								0: v = 32'h8000_0000;
								1: v = 32'h7FFF_FFFF;
								2: v = 32'h0000_0000;
								3: v = 32'h0001_0000;
								4: v = 32'hFFFF_0000;
								default: v = 32'hFFFF_FFFF;
							endcase
						end
						default: v = $urandom;
					endcase
					send_item(num, v, 1'($urandom_range(1)), i == len - 1);
					num = in_order ? num + 1'b1 : NUM_W'($urandom_range(1023));
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (failures == 0)
			$display("branching_variable_selector_unit_test: done, clean");
		else
			$display("branching_variable_selector_unit_test: done, errors");
		$finish;
	end

endmodule
